// ----- sv/wta_pkg.sv -----
// Shared types, constants and helpers for the weekly time alarm.
package wta_pkg;

   localparam int unsigned EPOCH_W   = 32;
   localparam int unsigned DAY_W     = 16;
   localparam int unsigned SOD_W     = 17;
   localparam int unsigned WD_W      = 3;
   localparam int unsigned DAY_LOW_W = 8;
   localparam int unsigned LANES     = 7;
   localparam int unsigned MASK_W    = 7;
   localparam int unsigned HOUR_W    = 5;
   localparam int unsigned MINUTE_W  = 6;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_W     = 7;

   // Time constants
   localparam logic [EPOCH_W-1:0] SEC_PER_DAY  = 32'd86400;
   localparam logic [SOD_W-1:0]   SEC_PER_HOUR = 17'd3600;
   localparam logic [SOD_W-1:0]   SEC_PER_MIN  = 17'd60;
   localparam logic [HOUR_W-1:0]  HOURS_PER_DAY   = 5'd24;
   localparam logic [MINUTE_W-1:0] MIN_PER_HOUR   = 6'd60;
   localparam logic [WD_W-1:0]    DAY0_WEEKDAY = 3'd4;
   localparam logic [EPOCH_W-1:0] NONE32       = '1;
   localparam logic [DAY_LOW_W-1:0] DAY_LOW_RST = 8'hFF;

   // epoch / 86400 = ((epoch >> 7) * DAY_RECIP) >> DAY_RECIP_SHIFT, exact for 32-bit epochs
   localparam int unsigned DAY_PRE_SHIFT   = 7;
   localparam int unsigned DAY_RECIP_W     = 26;
   localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 26'd50903317;
   localparam int unsigned DAY_RECIP_SHIFT = 35;

   // x / 7 for x < 2^16 = (x * WD_RECIP) >> WD_RECIP_SHIFT
   localparam logic [SOD_W-1:0] WD_RECIP = 17'd74899;
   localparam int unsigned WD_RECIP_SHIFT = 19;
   localparam int unsigned WD_Q_W         = 13;

   // 2^32 = 49710 days + 23296 s. A lane whose time wraps lands on an earlier day.
   localparam logic [SOD_W-1:0]   WRAP_SOD     = 17'd23296;
   localparam logic [EPOCH_W-1:0] WRAP_ADJ_HI  = 32'd23296;      // -49710 days mod 2^32
   localparam logic [EPOCH_W-1:0] WRAP_ADJ_LO  = 32'hFFFF_0980;  // -49711 days mod 2^32
   localparam logic [WD_W-1:0]    WRAP_WD_HI   = 3'd4;           // -49710 mod 7
   localparam logic [WD_W-1:0]    WRAP_WD_LO   = 3'd3;           // -49711 mod 7

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WEEKDAY_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_HOUR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_MINUTE = 2'd2;

   typedef struct packed {
      logic ld2;
      logic ld3;
      logic ld4;
      logic ld_out;
   } adv_type;

   typedef struct packed {
      logic [MASK_W-1:0]   weekday_mask;
      logic [HOUR_W-1:0]   alarm_hour;
      logic [MINUTE_W-1:0] alarm_minute;
   } cfg_type;

   typedef struct packed {
      logic [EPOCH_W-1:0]   epoch;
      logic [SOD_W-1:0]     sod;
      logic [WD_W-1:0]      wd;
      logic [EPOCH_W-1:0]   base;
      logic [DAY_LOW_W-1:0] day_low;
   } s3_type;

   typedef struct packed {
      logic                           epoch_nz;
      logic [DAY_LOW_W-1:0]           day_low;
      logic [WD_W-1:0]                wd;
      logic                           tmatch;
      logic [LANES-1:0]               sel;
      logic [LANES-1:0][EPOCH_W-1:0]  diff;
   } s4_type;

   // mod 7 of a small sum (at most 20)
   function automatic logic [WD_W-1:0] mod7_small(input logic [4:0] v);
      logic [4:0] r;
      if (v >= 5'd14) begin
         r = v - 5'd14;
      end else if (v >= 5'd7) begin
         r = v - 5'd7;
      end else begin
         r = v;
      end
      return r[WD_W-1:0];
   endfunction

endpackage

// ----- sv/wta_divide.sv -----
// Day number, second of day, weekday and day base from the epoch (two stages).
module wta_divide (
   input  logic                            clock,
   input  wta_pkg::adv_type                adv,
   input  logic [wta_pkg::EPOCH_W-1:0]     s1_epoch,
   output wta_pkg::s3_type                 s3
);

   localparam int unsigned PRE_W  = wta_pkg::EPOCH_W - wta_pkg::DAY_PRE_SHIFT;
   localparam int unsigned PROD_W = PRE_W + wta_pkg::DAY_RECIP_W;
   localparam int unsigned WDP_W  = 2 * wta_pkg::SOD_W;

   logic [wta_pkg::EPOCH_W-1:0] epoch2_ff;
   logic [wta_pkg::DAY_W-1:0]   day2_ff;
   logic [wta_pkg::DAY_W-1:0]   day2_in;
   logic [PROD_W-1:0]           day_prod;

   logic [wta_pkg::EPOCH_W-1:0] base;
   logic [wta_pkg::SOD_W-1:0]   dp4;
   logic [WDP_W-1:0]            q_prod;
   logic [wta_pkg::WD_Q_W-1:0]  q;
   logic [wta_pkg::SOD_W-1:0]   wd_full;
   wta_pkg::s3_type             s3_in;
   wta_pkg::s3_type             s3_ff;

   // stage 2: reciprocal multiply for the day number
   assign day_prod = PROD_W'(s1_epoch[wta_pkg::EPOCH_W-1:wta_pkg::DAY_PRE_SHIFT])
                   * PROD_W'(wta_pkg::DAY_RECIP);
   assign day2_in  = day_prod[wta_pkg::DAY_RECIP_SHIFT +: wta_pkg::DAY_W];

   always_ff @(posedge clock) begin
      if (adv.ld2) begin
         epoch2_ff <= s1_epoch;
         day2_ff   <= day2_in;
      end
   end

   // stage 3: remainder and weekday
   always_comb begin
      base    = wta_pkg::EPOCH_W'(day2_ff) * wta_pkg::SEC_PER_DAY;
      dp4     = wta_pkg::SOD_W'(day2_ff) + wta_pkg::SOD_W'(wta_pkg::DAY0_WEEKDAY);
      q_prod  = WDP_W'(dp4) * WDP_W'(wta_pkg::WD_RECIP);
      q       = q_prod[wta_pkg::WD_RECIP_SHIFT +: wta_pkg::WD_Q_W];
      wd_full = dp4 - ((wta_pkg::SOD_W'(q) << 3) - wta_pkg::SOD_W'(q));

      s3_in.epoch   = epoch2_ff;
      s3_in.base    = base;
      s3_in.sod     = wta_pkg::SOD_W'(epoch2_ff - base);
      s3_in.wd      = wd_full[wta_pkg::WD_W-1:0];
      s3_in.day_low = day2_ff[wta_pkg::DAY_LOW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv.ld3) begin
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

// ----- sv/wta_lanes.sv -----
// Seven day lanes of the next-wake search plus the alarm time window test.
module wta_lanes (
   input  logic               clock,
   input  wta_pkg::adv_type   adv,
   input  wta_pkg::cfg_type   cfg,
   input  wta_pkg::s3_type    s3,
   output wta_pkg::s4_type    s4
);

   localparam int unsigned EW = wta_pkg::EPOCH_W;

   logic [wta_pkg::SOD_W-1:0]                asod;
   logic                                     hour_ok;
   logic                                     minute_ok;
   logic [wta_pkg::LANES-1:0][EW-1:0]        off;
   logic [wta_pkg::LANES-1:0][EW:0]          sum;
   logic [wta_pkg::LANES-1:0][EW-1:0]        kofs;
   logic [wta_pkg::LANES-1:0][EW-1:0]        tgt;
   logic [wta_pkg::LANES-1:0][wta_pkg::WD_W-1:0] wd_shift;
   logic [wta_pkg::LANES-1:0][wta_pkg::WD_W-1:0] wdt;
   wta_pkg::s4_type                          s4_in;
   wta_pkg::s4_type                          s4_ff;

   always_comb begin
      asod = wta_pkg::SOD_W'(cfg.alarm_hour) * wta_pkg::SEC_PER_HOUR
           + wta_pkg::SOD_W'(cfg.alarm_minute) * wta_pkg::SEC_PER_MIN;
      hour_ok   = cfg.alarm_hour < wta_pkg::HOURS_PER_DAY;
      minute_ok = cfg.alarm_minute < wta_pkg::MIN_PER_HOUR;

      for (int d = 0; d < wta_pkg::LANES; d++) begin
         off[d] = EW'(d) * wta_pkg::SEC_PER_DAY;
         sum[d] = {1'b0, s3.epoch} + {1'b0, off[d]};
         // lane time wraps past 2^32: pull back to the wrapped day
         if (!sum[d][EW]) begin
            kofs[d]     = off[d] + EW'(asod);
            wd_shift[d] = '0;
         end else if (s3.sod >= wta_pkg::WRAP_SOD) begin
            kofs[d]     = off[d] + wta_pkg::WRAP_ADJ_HI + EW'(asod);
            wd_shift[d] = wta_pkg::WRAP_WD_HI;
         end else begin
            kofs[d]     = off[d] + wta_pkg::WRAP_ADJ_LO + EW'(asod);
            wd_shift[d] = wta_pkg::WRAP_WD_LO;
         end
         wdt[d] = wta_pkg::mod7_small(5'(s3.wd) + 5'(d) + 5'(wd_shift[d]));
         tgt[d] = s3.base + kofs[d];
         s4_in.diff[d] = kofs[d] - EW'(s3.sod);
         s4_in.sel[d]  = cfg.weekday_mask[wdt[d]] && (tgt[d] > s3.epoch);
      end

      s4_in.epoch_nz = |s3.epoch;
      s4_in.day_low  = s3.day_low;
      s4_in.wd       = s3.wd;
      s4_in.tmatch   = hour_ok && minute_ok && (s3.sod >= asod)
                    && (s3.sod < asod + wta_pkg::SEC_PER_MIN);
   end

   always_ff @(posedge clock) begin
      if (adv.ld4) begin
         s4_ff <= s4_in;
      end
   end

   assign s4 = s4_ff;

endmodule

// ----- sv/wta_state.sv -----
// Alarm state update, next-wake pick and the result register.
module wta_state (
   input  logic                            clock,
   input  logic                            reset,
   input  wta_pkg::adv_type                adv,
   input  wta_pkg::cfg_type                cfg,
   input  wta_pkg::s4_type                 s4,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic                            rsp_wake_fire,
   output logic [wta_pkg::EPOCH_W-1:0]     rsp_seconds_to_wake,
   output logic                            rsp_alarm_active
);

   logic                              active_ff, active_in;
   logic                              fired_ff, fired_in;
   logic [wta_pkg::DAY_LOW_W-1:0]     last_day_ff, last_day_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              fire_ff, fire_in;
   logic [wta_pkg::EPOCH_W-1:0]       wake_ff, wake_in;
   logic                              live;
   logic                              fired_eff;
   logic [wta_pkg::EPOCH_W-1:0]       pick;

   always_comb begin
      active_in = active_ff | (s4.epoch_nz & (|cfg.weekday_mask));
      live      = active_in & s4.epoch_nz;
      fired_eff = (s4.day_low != last_day_ff) ? 1'b0 : fired_ff;
      fire_in   = live & ~fired_eff & cfg.weekday_mask[s4.wd] & s4.tmatch;
      fired_in  = live ? (fired_eff | fire_in) : fired_ff;
      last_day_in = live ? s4.day_low : last_day_ff;

      // first enabled lane wins
      pick = wta_pkg::NONE32;
      for (int d = wta_pkg::LANES - 1; d >= 0; d--) begin
         if (s4.sel[d]) begin
            pick = s4.diff[d];
         end
      end
      wake_in = live ? pick : wta_pkg::NONE32;

      rsp_valid_in = adv.ld_out | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         fired_ff     <= 1'b0;
         last_day_ff  <= wta_pkg::DAY_LOW_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv.ld_out) begin
            active_ff   <= active_in;
            fired_ff    <= fired_in;
            last_day_ff <= last_day_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv.ld_out) begin
         fire_ff <= fire_in;
         wake_ff <= wake_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_wake_fire       = fire_ff;
   assign rsp_seconds_to_wake = wake_ff;
   assign rsp_alarm_active    = active_ff;

endmodule

// ----- sv/weekly_time_alarm.sv -----
// Weekly time alarm top level: input register, pipeline control, registers.
//
// Each req item carries the current epoch in seconds; each produces exactly
// one rsp item: wake_fire (alarm hit, at most once per day), seconds_to_wake
// (seconds to the next enabled alarm within seven days, all ones if none)
// and alarm_active (latched once time is known with a nonzero weekday mask).
// An epoch of zero means time is unknown: no fire, seconds_to_wake all ones.
//
// Pipeline: input register, day divide, remainder/weekday, day lanes, result
// register. One item per cycle is sustained while rsp_stall stays low. The
// alarm state updates as an item enters the result register, so consecutive
// items see each other's effects in order.
//
// rsp_stall holds the result register; stages with bubbles keep filling, and
// req_stall rises only once every stage holds an item.
// Registers are written through csr_we/csr_index/csr_wdata; the user must write
// them only while no item is in flight (not enforced); unknown indexes are dropped.
// Reset (synchronous) empties the pipeline, clears the registers, the active
// and fired flags, and sets the last day mark to 255.
module weekly_time_alarm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [wta_pkg::EPOCH_W-1:0]        req_epoch_seconds,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_wake_fire,
   output logic [wta_pkg::EPOCH_W-1:0]        rsp_seconds_to_wake,
   output logic                               rsp_alarm_active,
   input  logic                               csr_we,
   input  logic [wta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wta_pkg::CSR_W-1:0]          csr_wdata
);

   logic [wta_pkg::EPOCH_W-1:0] epoch1_ff;
   logic                        v1_ff, v2_ff, v3_ff, v4_ff;
   logic                        v1_in, v2_in, v3_in, v4_in;
   logic                        mv1, mv2, mv3, mv4;
   logic                        ld1;
   wta_pkg::adv_type            adv;
   wta_pkg::cfg_type            cfg_ff, cfg_in;
   wta_pkg::s3_type             s3;
   wta_pkg::s4_type             s4;

   // elastic valid chain: a stage moves on when the next one is empty or moving
   always_comb begin
      mv4 = v4_ff & (~rsp_valid | ~rsp_stall);
      mv3 = v3_ff & (~v4_ff | mv4);
      mv2 = v2_ff & (~v3_ff | mv3);
      mv1 = v1_ff & (~v2_ff | mv2);
      req_stall = v1_ff & ~mv1;
      ld1 = req_valid & ~req_stall;

      v1_in = ld1 | (v1_ff & ~mv1);
      v2_in = mv1 | (v2_ff & ~mv2);
      v3_in = mv2 | (v3_ff & ~mv3);
      v4_in = mv3 | (v4_ff & ~mv4);

      adv.ld2    = mv1;
      adv.ld3    = mv2;
      adv.ld4    = mv3;
      adv.ld_out = mv4;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            wta_pkg::CSR_WEEKDAY_MASK: cfg_in.weekday_mask = csr_wdata[wta_pkg::MASK_W-1:0];
            wta_pkg::CSR_ALARM_HOUR:   cfg_in.alarm_hour   = csr_wdata[wta_pkg::HOUR_W-1:0];
            wta_pkg::CSR_ALARM_MINUTE: cfg_in.alarm_minute = csr_wdata[wta_pkg::MINUTE_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         cfg_ff <= '0;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         v4_ff  <= v4_in;
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         epoch1_ff <= req_epoch_seconds;
      end
   end

   wta_divide u_divide (
      .clock    (clock),
      .adv      (adv),
      .s1_epoch (epoch1_ff),
      .s3       (s3)
   );

   wta_lanes u_lanes (
      .clock (clock),
      .adv   (adv),
      .cfg   (cfg_ff),
      .s3    (s3),
      .s4    (s4)
   );

   wta_state u_state (
      .clock               (clock),
      .reset               (reset),
      .adv                 (adv),
      .cfg                 (cfg_ff),
      .s4                  (s4),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_wake_fire       (rsp_wake_fire),
      .rsp_seconds_to_wake (rsp_seconds_to_wake),
      .rsp_alarm_active    (rsp_alarm_active)
   );

endmodule

// ----- sv/wta_checker.sv -----
// Port-level checks for the weekly time alarm, bound to the top level.
module wta_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_wake_fire,
   input logic [wta_pkg::EPOCH_W-1:0]        rsp_seconds_to_wake,
   input logic                               rsp_alarm_active
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_seconds_to_wake)
         && $stable(rsp_wake_fire) && $stable(rsp_alarm_active))
      else $error("stalled rsp item changed");

   // a fire needs an active alarm
   a_fire_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_fire |-> rsp_alarm_active)
      else $error("wake_fire without alarm_active");

   // inactive alarm reports no next wake
   a_idle_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alarm_active |-> rsp_seconds_to_wake == wta_pkg::NONE32)
      else $error("seconds_to_wake set while inactive");

   // active flag never drops once shown
   a_active_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm_active |=> !(rsp_valid && !rsp_alarm_active))
      else $error("alarm_active dropped");

endmodule

bind weekly_time_alarm wta_checker u_wta_checker (.*);

// ----- tb/weekly_time_alarm_test.sv -----
// Self-checking testbench for the weekly time alarm: directed, random and backpressure runs.
module weekly_time_alarm_test;

   // Time constants for the alarm predictor, all at epoch width so that sums wrap at 2^32
   localparam logic [wta_pkg::EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [wta_pkg::EPOCH_W-1:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [wta_pkg::EPOCH_W-1:0] SECS_PER_MIN  = 32'd60;
   localparam logic [wta_pkg::EPOCH_W-1:0] EPOCH_WEEKDAY = 32'd4;    // day zero was a Thursday
   localparam logic [wta_pkg::EPOCH_W-1:0] DAYS_PER_WEEK = 32'd7;
   localparam logic [wta_pkg::EPOCH_W-1:0] NO_WAKE       = '1;

   // Index with no register behind it; writes to it must be dropped
   localparam logic [wta_pkg::CSR_IDX_W-1:0] CSR_NO_REG = 2'd3;

   localparam int unsigned LONG_HOLD       = 60;    // receiver hold-off for the fill test
   localparam int unsigned WATCHDOG_LIMIT  = 2000;  // cycles with no item moving on either side
   localparam int unsigned SETTLE_CYCLES   = 8;     // settle time after the final drain
   localparam int unsigned PHASES          = 8;
   localparam int unsigned ITEMS_PER_PHASE = 40;
   localparam int unsigned FILL_ITEMS      = 30;
   localparam int unsigned BASE_DAY        = 19000;

   typedef struct packed {
      logic                          wake_fire;
      logic [wta_pkg::EPOCH_W-1:0]   seconds_to_wake;
      logic                          alarm_active;
   } wake_result_type;

   // How a run of clock ticks starts
   typedef enum logic [1:0] {
      START_NEAR_ALARM,
      START_RANDOM,
      START_NEAR_WRAP,
      START_EARLY
   } run_start_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [wta_pkg::EPOCH_W-1:0]     req_epoch_seconds;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_wake_fire;
   logic [wta_pkg::EPOCH_W-1:0]     rsp_seconds_to_wake;
   logic                            rsp_alarm_active;
   logic                            csr_we;
   logic [wta_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [wta_pkg::CSR_W-1:0]       csr_wdata;

   weekly_time_alarm dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_epoch_seconds   (req_epoch_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_wake_fire       (rsp_wake_fire),
      .rsp_seconds_to_wake (rsp_seconds_to_wake),
      .rsp_alarm_active    (rsp_alarm_active),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: mirrored alarm registers and the block's flags
   logic [wta_pkg::MASK_W-1:0]      cfg_mask;
   logic [wta_pkg::HOUR_W-1:0]      cfg_hour;
   logic [wta_pkg::MINUTE_W-1:0]    cfg_minute;
   logic                            alarm_armed;
   logic                            fired_today;
   logic [wta_pkg::DAY_LOW_W-1:0]   last_day_low;

   wake_result_type        expected_results[$];
   int unsigned            error_count = 0;

   // Idling controls shared by the stimulus and the receiver
   logic                   send_eager = 1'b0;
   logic                   rsp_eager = 1'b0;
   logic                   hold_request;
   int unsigned            hold_count = 0;
   int unsigned            stall_left = 0;
   int unsigned            quiet_cycles = 0;

   function automatic logic [2:0] weekday_of(input logic [wta_pkg::EPOCH_W-1:0] t);
      return 3'((t / SECS_PER_DAY + EPOCH_WEEKDAY) % DAYS_PER_WEEK);
   endfunction

   // Advance the alarm state by one clock tick and return what the block should report.
   // The flag, day tracking and fire test come first; the next-wake search sees the new flag.
   function automatic wake_result_type predict_tick(input logic [wta_pkg::EPOCH_W-1:0] epoch);
      wake_result_type               r;
      logic [wta_pkg::EPOCH_W-1:0]   day;
      logic [wta_pkg::EPOCH_W-1:0]   sod;
      logic [wta_pkg::EPOCH_W-1:0]   t;
      logic [wta_pkg::EPOCH_W-1:0]   target;
      logic                          found;
      r.wake_fire = 1'b0;
      r.seconds_to_wake = NO_WAKE;
      found = 1'b0;
      if (!alarm_armed && epoch != '0 && cfg_mask != '0) begin
         alarm_armed = 1'b1;
      end
      if (alarm_armed && epoch != '0) begin
         day = epoch / SECS_PER_DAY;
         // only the low byte of the day number is tracked
         if (day[wta_pkg::DAY_LOW_W-1:0] != last_day_low) begin
            fired_today = 1'b0;
            last_day_low = day[wta_pkg::DAY_LOW_W-1:0];
         end
         sod = epoch % SECS_PER_DAY;
         if (!fired_today && cfg_mask[weekday_of(epoch)]
             && sod / SECS_PER_HOUR == 32'(cfg_hour)
             && (sod % SECS_PER_HOUR) / SECS_PER_MIN == 32'(cfg_minute)) begin
            fired_today = 1'b1;
            r.wake_fire = 1'b1;
         end
         // first enabled day, up to a week out, whose alarm time still lies ahead
         for (int d = 0; d < DAYS_PER_WEEK && !found; d++) begin
            t = epoch + 32'(d) * SECS_PER_DAY;
            if (cfg_mask[weekday_of(t)]) begin
               target = (t / SECS_PER_DAY) * SECS_PER_DAY
                      + 32'(cfg_hour) * SECS_PER_HOUR + 32'(cfg_minute) * SECS_PER_MIN;
               if (target > epoch) begin
                  r.seconds_to_wake = target - epoch;
                  found = 1'b1;
               end
            end
         end
      end
      r.alarm_active = alarm_armed;
      return r;
   endfunction

   // Offer one tick, hold it until taken, then record what it should produce
   task automatic send_epoch(input logic [wta_pkg::EPOCH_W-1:0] epoch);
      int unsigned gap;
      gap = send_eager ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= epoch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_tick(epoch));
   endtask

   // Stop offering and wait until every outstanding result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Caller lowers csr_we after the last write of a group
   task automatic write_reg(input logic [wta_pkg::CSR_IDX_W-1:0] index,
                            input logic [wta_pkg::CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         wta_pkg::CSR_WEEKDAY_MASK: cfg_mask = value[wta_pkg::MASK_W-1:0];
         wta_pkg::CSR_ALARM_HOUR:   cfg_hour = value[wta_pkg::HOUR_W-1:0];
         wta_pkg::CSR_ALARM_MINUTE: cfg_minute = value[wta_pkg::MINUTE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_alarm(input logic [wta_pkg::CSR_W-1:0] mask,
                            input logic [wta_pkg::CSR_W-1:0] hour,
                            input logic [wta_pkg::CSR_W-1:0] minute);
      drain_results();
      write_reg(wta_pkg::CSR_WEEKDAY_MASK, mask);
      write_reg(wta_pkg::CSR_ALARM_HOUR, hour);
      write_reg(wta_pkg::CSR_ALARM_MINUTE, minute);
      csr_we <= 1'b0;
   endtask

   function automatic logic [wta_pkg::EPOCH_W-1:0] alarm_time(input longint day,
                                                             input longint offset);
      return 32'(day * 86400 + longint'(cfg_hour) * 3600 + longint'(cfg_minute) * 60 + offset);
   endfunction

   function automatic logic [wta_pkg::EPOCH_W-1:0] run_start();
      run_start_type kind;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: kind = START_NEAR_ALARM;
         5, 6:          kind = START_RANDOM;
         7:             kind = START_NEAR_WRAP;
         default:       kind = START_EARLY;
      endcase
      case (kind)
         START_NEAR_ALARM: return alarm_time($urandom_range(0, 49710), -$urandom_range(0, 120));
         START_RANDOM:     return $urandom();
         START_NEAR_WRAP:  return NO_WAKE - $urandom_range(0, 8 * 86400);
         default:          return $urandom_range(1, 8 * 86400);
      endcase
   endfunction

   // Mostly clock-like steps, sometimes whole days, sometimes a jump that aliases the day byte
   function automatic logic [wta_pkg::EPOCH_W-1:0] run_step(
      input logic [wta_pkg::EPOCH_W-1:0] epoch);
      case ($urandom_range(0, 19))
         0:       return epoch + SECS_PER_DAY * $urandom_range(1, 7);
         1:       return epoch + SECS_PER_DAY * 256;
         default: return epoch + $urandom_range(1, 40);
      endcase
   endfunction

   task automatic send_runs(input int unsigned count);
      logic [wta_pkg::EPOCH_W-1:0] epoch;
      int unsigned                 sent;
      int unsigned                 run_len;
      sent = 0;
      while (sent < count) begin
         run_len = $urandom_range(1, 12);
         epoch = run_start();
         repeat (run_len) begin
            // a lost time source now and then, without breaking the run
            if ($urandom_range(0, 15) == 0) begin
               send_epoch('0);
            end else begin
               send_epoch(epoch);
               epoch = run_step(epoch);
            end
            sent++;
         end
      end
   endtask

   // No mask yet: nothing latches, whatever the clock says; stray index write is dropped
   task automatic test_before_time_known();
      drain_results();
      write_reg(wta_pkg::CSR_ALARM_HOUR, 7'd3);
      write_reg(wta_pkg::CSR_ALARM_MINUTE, 7'd4);
      write_reg(CSR_NO_REG, 7'h7F);
      csr_we <= 1'b0;
      send_epoch('0);
      send_epoch(32'h1234_5678);
      send_epoch(NO_WAKE);
   endtask

   // Once per day, rearm on a new day, but not when the day byte aliases
   task automatic test_daily_fire();
      set_alarm(7'h7F, 7'd7, 7'd30);
      send_epoch(alarm_time(BASE_DAY, -1));    // latches active, one second to go
      send_epoch(alarm_time(BASE_DAY, 0));
      send_epoch(alarm_time(BASE_DAY, 30));    // same minute, already fired
      send_epoch('0);
      send_epoch(alarm_time(BASE_DAY + 1, 59));
      send_epoch(alarm_time(BASE_DAY + 257, 0));  // same low day byte: stays fired
      send_epoch(alarm_time(BASE_DAY + 258, 0));
   endtask

   task automatic test_field_extremes();
      set_alarm(7'h7F, 7'd23, 7'd59);
      send_epoch(NO_WAKE);
      send_epoch(NO_WAKE - 3 * SECS_PER_DAY);
      send_epoch(32'd1);
      send_epoch(SECS_PER_DAY - 1);
      send_epoch(SECS_PER_DAY);
      send_epoch(alarm_time(49709, 0));        // last full day before the wrap
      // all wdata bits set: hour and minute out of range, never match
      set_alarm(7'h7F, 7'h7F, 7'h7F);
      send_epoch(alarm_time(BASE_DAY, 0));
      send_epoch(NO_WAKE - 100);
      set_alarm(7'h01, 7'd0, 7'd0);
      send_epoch(32'hFFFF_FF00);
      send_epoch(alarm_time(3, 0));            // a Sunday at midnight
   endtask

   // Active stays latched, but with no day enabled nothing is scheduled
   task automatic test_mask_cleared();
      set_alarm(7'h00, 7'd7, 7'd30);
      send_epoch(alarm_time(BASE_DAY + 300, 0));
      send_epoch(32'hDEAD_BEEF);
      send_epoch('0);
   endtask

   task automatic test_random_traffic();
      logic [wta_pkg::CSR_W-1:0] mask;
      logic [wta_pkg::CSR_W-1:0] hour;
      logic [wta_pkg::CSR_W-1:0] minute;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin mask = 7'h7F; hour = 7'd0;  minute = 7'd0;  end
            1: begin mask = 7'h7F; hour = 7'd23; minute = 7'd59; end
            2: begin mask = 7'h01; hour = 7'd12; minute = 7'd0;  end
            3: begin mask = 7'h40; hour = 7'd31; minute = 7'd63; end
            default: begin
               mask = ($urandom_range(0, 7) == 0) ? 7'h00 : 7'($urandom_range(1, 127));
               hour = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 31))
                                                 : 7'($urandom_range(0, 23));
               minute = 7'($urandom_range(0, 63));
            end
         endcase
         set_alarm(mask, hour, minute);
         // some phases run back to back on one or both sides
         send_eager = ($urandom_range(0, 3) == 0);
         rsp_eager = ($urandom_range(0, 3) == 0);
         send_runs(ITEMS_PER_PHASE);
      end
      send_eager = 1'b0;
      rsp_eager = 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering, so the pipeline fills and req_stall rises
   task automatic test_backpressure();
      set_alarm(7'h55, 7'd6, 7'd15);
      send_eager = 1'b1;
      hold_request <= 1'b1;
      send_runs(FILL_ITEMS);
      send_eager = 1'b0;
   endtask

   // Receiver: random stall after each taken result, or a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_request) begin
         rsp_stall <= 1'b1;
         hold_count++;
         if (hold_count >= LONG_HOLD) begin
            hold_request <= 1'b0;
            hold_count = 0;
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            stall_left = rsp_eager ? 0 : $urandom_range(0, 5);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each taken result against the oldest prediction
   always @(posedge clock) begin : check_results
      wake_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result fire=%0d wake=%0d active=%0d", $time,
                     rsp_wake_fire, rsp_seconds_to_wake, rsp_alarm_active);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_wake_fire !== want.wake_fire) begin
               $display("%0t: wake_fire expected %0d got %0d", $time,
                        want.wake_fire, rsp_wake_fire);
               error_count++;
            end
            if (rsp_seconds_to_wake !== want.seconds_to_wake) begin
               $display("%0t: seconds_to_wake expected %0d got %0d", $time,
                        want.seconds_to_wake, rsp_seconds_to_wake);
               error_count++;
            end
            if (rsp_alarm_active !== want.alarm_active) begin
               $display("%0t: alarm_active expected %0d got %0d", $time,
                        want.alarm_active, rsp_alarm_active);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long with nothing moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_epoch_seconds <= '0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      hold_request <= 1'b0;
      // predictor starts from the reset state
      cfg_mask = '0;
      cfg_hour = '0;
      cfg_minute = '0;
      alarm_armed = 1'b0;
      fired_today = 1'b0;
      last_day_low = wta_pkg::DAY_LOW_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_before_time_known();
      test_daily_fire();
      test_field_extremes();
      test_mask_cleared();
      test_random_traffic();
      test_backpressure();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
